@@ hdl/mqlp_pkg.sv @@
// Shared constants and types for the multi-queue linked node pool.
package mqlp_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int NUM_QUEUES = 3;
	localparam int POOL_DEPTH = 64;

	localparam int PTR_W   = $clog2(POOL_DEPTH);
	localparam int QUEUE_W = 2;
	localparam int QSLOTS  = 2 ** QUEUE_W;

	localparam logic FUNC_ENQ = 1'b0;
	localparam logic FUNC_DEQ = 1'b1;

	typedef logic [1:0] status_t;

	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_EMPTY = 2'd1;
	localparam status_t ST_FULL  = 2'd2;

	localparam logic signed [DATA_WIDTH-1:0] EMPTY_VALUE = DATA_WIDTH'(-999);

	typedef logic [PTR_W-1:0] ptr_t;

endpackage

@@ hdl/mqlp_if.sv @@
// Request and response channel interfaces of the multi-queue linked node pool.
interface mqlp_req_if import mqlp_pkg::*;;
	logic                         valid;
	logic                         ready;
	logic                         func;
	logic [QUEUE_W-1:0]           queue_id;
	logic signed [DATA_WIDTH-1:0] data_in;

	modport source (output valid, func, queue_id, data_in, input ready);
	modport sink   (input valid, func, queue_id, data_in, output ready);
endinterface

interface mqlp_rsp_if import mqlp_pkg::*;;
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] data_out;
	status_t                      status;

	modport source (output valid, data_out, status, input ready);
	modport sink   (input valid, data_out, status, output ready);
endinterface

@@ hdl/multi_queue_linked_pool.sv @@
// Top level: several FIFO queues sharing one linked node pool with a free list.
//
// Request channel (req): func 0 enqueues data_in on queue queue_id, func 1
// dequeues the head value of that queue. Response channel (rsp): one beat per
// request, data_out and status (ok, queue empty, pool full). An empty dequeue
// returns -999; an enqueue with no free node, or to a queue number past the
// last queue, is dropped with status full and data_out 0.
//
// Node values and links live in two synchronous RAMs. A request beat issues the
// RAM read (head node for a dequeue, free-list top for an enqueue); the read
// data comes back registered, and the pointers, RAMs and response register are
// updated once the response register is free. The next request is taken the
// cycle after the update, so the block takes no new request until the last one
// is through the read-modify-write of the RAMs.
//
// Reset (arst_n low) empties all queues and the free list; the RAMs are not
// cleared, since no read data is used before its entry is written. If the
// receiver stalls, the finished response holds in the output register, one
// more request is still taken, and its update waits until that register frees.
module multi_queue_linked_pool import mqlp_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	mqlp_req_if.sink   req,
	mqlp_rsp_if.source rsp
);

	// Pointer state per queue; slots past the last queue are written only by reset.
	ptr_t             head_q [QSLOTS];
	ptr_t             tail_q [QSLOTS];
	logic [QSLOTS-1:0] nonempty_q;

	// Allocator: count of nodes taken from the never-used range, plus the free-list top.
	logic [PTR_W:0] fresh_q;
	ptr_t           rec_head_q;
	logic           rec_valid_q;

	// Request in flight between the RAM read and the update.
	logic                         busy_q;
	logic                         func_s1;
	logic [QUEUE_W-1:0]           qid_s1;
	logic signed [DATA_WIDTH-1:0] data_s1;

	// Response register.
	logic                         out_valid_q;
	logic signed [DATA_WIDTH-1:0] out_data_q;
	status_t                      out_status_q;

	logic accept;
	logic done;

	// RAM ports.
	ptr_t                  rd_addr;
	logic [DATA_WIDTH-1:0] val_rdata;
	ptr_t                  link_rdata;
	logic                  val_we;
	ptr_t                  val_waddr;
	logic                  link_we;
	ptr_t                  link_waddr;
	ptr_t                  link_wdata;

	// Update decisions.
	logic    q_ok;
	logic    enq_go;
	logic    deq_go;
	ptr_t    new_node;
	ptr_t    cur_head;
	ptr_t    cur_tail;
	status_t nxt_status;
	logic signed [DATA_WIDTH-1:0] nxt_data;

	assign accept    = req.valid && req.ready;
	assign req.ready = !busy_q;
	// Hold the update while a finished response still waits to be taken.
	assign done      = busy_q && (!out_valid_q || rsp.ready);

	// Read address: free-list top for an enqueue, queue head for a dequeue.
	assign rd_addr = (req.func == FUNC_DEQ) ? head_q[req.queue_id] : rec_head_q;

	mqlp_ram #(.WIDTH(DATA_WIDTH), .DEPTH(POOL_DEPTH)) u_value_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (val_waddr),
		.wdata (data_s1),
		.re    (accept),
		.raddr (rd_addr),
		.rdata (val_rdata)
	);

	mqlp_ram #(.WIDTH(PTR_W), .DEPTH(POOL_DEPTH)) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.re    (accept),
		.raddr (rd_addr),
		.rdata (link_rdata)
	);

	assign q_ok     = qid_s1 < QUEUE_W'(NUM_QUEUES);
	assign cur_head = head_q[qid_s1];
	assign cur_tail = tail_q[qid_s1];
	// Recycled node first, else the next never-used one.
	assign new_node = rec_valid_q ? rec_head_q : fresh_q[PTR_W-1:0];

	always_comb begin
		enq_go     = 1'b0;
		deq_go     = 1'b0;
		nxt_status = ST_OK;
		nxt_data   = '0;
		val_we     = 1'b0;
		val_waddr  = new_node;
		link_we    = 1'b0;
		link_waddr = cur_tail;
		link_wdata = new_node;
		if (func_s1 == FUNC_ENQ) begin
			if (!q_ok || (!rec_valid_q && fresh_q == (PTR_W + 1)'(POOL_DEPTH))) begin
				nxt_status = ST_FULL;
			end else begin
				enq_go  = 1'b1;
				val_we  = done;
				// Append behind the current tail when the queue holds nodes.
				link_we = done && nonempty_q[qid_s1];
			end
		end else begin
			if (!q_ok || !nonempty_q[qid_s1]) begin
				nxt_status = ST_EMPTY;
				nxt_data   = EMPTY_VALUE;
			end else begin
				deq_go     = 1'b1;
				nxt_data   = signed'(val_rdata);
				// Push the freed head onto the free list; the bottom links to itself.
				link_we    = done;
				link_waddr = cur_head;
				link_wdata = rec_valid_q ? rec_head_q : cur_head;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			fresh_q     <= '0;
			rec_head_q  <= '0;
			rec_valid_q <= 1'b0;
			nonempty_q  <= '0;
			for (int i = 0; i < QSLOTS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
			end
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (done) begin
				busy_q <= 1'b0;
			end

			if (done) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			if (done && enq_go) begin
				if (rec_valid_q) begin
					// Pop the free list; a self link marks its bottom.
					if (link_rdata == rec_head_q) begin
						rec_valid_q <= 1'b0;
					end else begin
						rec_head_q <= link_rdata;
					end
				end else begin
					fresh_q <= fresh_q + 1'b1;
				end
				if (!nonempty_q[qid_s1]) begin
					head_q[qid_s1]     <= new_node;
					nonempty_q[qid_s1] <= 1'b1;
				end
				tail_q[qid_s1] <= new_node;
			end

			if (done && deq_go) begin
				if (cur_head == cur_tail) begin
					nonempty_q[qid_s1] <= 1'b0;
				end else begin
					head_q[qid_s1] <= link_rdata;
				end
				rec_head_q  <= cur_head;
				rec_valid_q <= 1'b1;
			end
		end
	end

	// Payload registers: capture the request, load the response.
	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1 <= req.func;
			qid_s1  <= req.queue_id;
			data_s1 <= req.data_in;
		end
		if (done) begin
			out_data_q   <= nxt_data;
			out_status_q <= nxt_status;
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.data_out = out_data_q;
	assign rsp.status   = out_status_q;

`ifndef NO_ASSERTIONS
	// An update never overwrites a response that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(out_valid_q && !rsp.ready))
		else $error("response register overwritten");

	// The count of nodes taken from the never-used range stays within the pool.
	a_fresh_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fresh_q <= (PTR_W + 1)'(POOL_DEPTH))
		else $error("fresh node count past pool depth");

	// RAM writes happen only while an update completes.
	a_write_in_update: assert property (@(posedge clk) disable iff (!arst_n)
		(val_we || link_we) |-> done)
		else $error("RAM write outside an update");

	// A request beat is followed by a busy cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy_q)
		else $error("request not held for update");
`endif

endmodule

@@ hdl/mqlp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module mqlp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ test/multi_queue_linked_pool_tb.sv @@
// Self-checking testbench for the multi-queue linked node pool: random bursts, stalls, scoreboard.
`timescale 1ns / 1ps

module multi_queue_linked_pool_tb import mqlp_pkg::*;;

	localparam int RANDOM_BEATS  = 950;
	localparam int IDLE_LIMIT    = 2000;  // cycles with no beat on either channel
	localparam int HOLD_OFF_LEN  = 300;   // long receiver hold-off, well under IDLE_LIMIT
	localparam int DRAIN_CYCLES  = 8;

	typedef struct {
		logic signed [DATA_WIDTH-1:0] value;
		status_t                      status;
	} pool_response_t;

	// Shadow of the queue manager: per-queue head/tail, node pool, free list,
	// and the responses still owed by the block in request order.
	class pool_scoreboard_t;
		logic signed [DATA_WIDTH-1:0] node_value [POOL_DEPTH];
		ptr_t                         node_link  [POOL_DEPTH];
		ptr_t                         head       [NUM_QUEUES];
		ptr_t                         tail       [NUM_QUEUES];
		bit                           occupied   [NUM_QUEUES];
		int unsigned                  fresh_count;
		ptr_t                         free_top;
		bit                           free_nonempty;
		pool_response_t               owed [$];
		int                           errors;

		function new();
			foreach (head[q]) begin
				head[q]     = '0;
				tail[q]     = '0;
				occupied[q] = 1'b0;
			end
			fresh_count   = 0;
			free_top      = '0;
			free_nonempty = 1'b0;
			errors        = 0;
		endfunction

		// Recycled nodes first, then never-used ones.
		function bit take_node(output ptr_t node);
			node = '0;
			if (free_nonempty) begin
				node = free_top;
				if (node_link[node] == node)
					free_nonempty = 1'b0;
				else
					free_top = node_link[node];
				return 1'b1;
			end
			if (fresh_count < POOL_DEPTH) begin
				node = ptr_t'(fresh_count);
				fresh_count++;
				return 1'b1;
			end
			return 1'b0;
		endfunction

		function void note_request(logic func, logic [QUEUE_W-1:0] qid,
		                           logic signed [DATA_WIDTH-1:0] data);
			pool_response_t rsp;
			ptr_t           node;
			rsp.value  = '0;
			rsp.status = ST_OK;
			if (func == FUNC_ENQ) begin
				if (qid >= NUM_QUEUES) begin
					rsp.status = ST_FULL;
				end else if (!take_node(node)) begin
					rsp.status = ST_FULL;
				end else begin
					node_value[node] = data;
					if (occupied[qid]) begin
						node_link[tail[qid]] = node;
					end else begin
						head[qid]     = node;
						occupied[qid] = 1'b1;
					end
					tail[qid] = node;
				end
			end else begin
				if (qid >= NUM_QUEUES || !occupied[qid]) begin
					rsp.value  = EMPTY_VALUE;
					rsp.status = ST_EMPTY;
				end else begin
					node      = head[qid];
					rsp.value = node_value[node];
					if (node == tail[qid])
						occupied[qid] = 1'b0;
					else
						head[qid] = node_link[node];
					// push onto the free list; the bottom node links to itself
					node_link[node] = free_nonempty ? free_top : node;
					free_top        = node;
					free_nonempty   = 1'b1;
				end
			end
			owed.push_back(rsp);
		endfunction

		function void check_response(logic signed [DATA_WIDTH-1:0] value, status_t status);
			pool_response_t exp_rsp;
			if (owed.size() == 0) begin
				$display("%0t: response with none outstanding: data_out %0d status %0d",
				         $time, value, status);
				errors++;
				return;
			end
			exp_rsp = owed.pop_front();
			if (value !== exp_rsp.value) begin
				$display("%0t: data_out mismatch: expected %0d actual %0d",
				         $time, exp_rsp.value, value);
				errors++;
			end
			if (status !== exp_rsp.status) begin
				$display("%0t: status mismatch: expected %0d actual %0d",
				         $time, exp_rsp.status, status);
				errors++;
			end
		endfunction

		function int pending();
			return owed.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	mqlp_req_if req_ch ();
	mqlp_rsp_if rsp_ch ();

	multi_queue_linked_pool dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	pool_scoreboard_t sb = new();
	int               idle_cycles;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Monitor both channels at the edge. Check the response before noting a new
	// request so the expectation store is always consumed oldest first. Count
	// cycles without any beat and bail out if the block seems hung.
	always @(posedge clk) begin
		if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
			sb.check_response(rsp_ch.data_out, rsp_ch.status);
		if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
			sb.note_request(req_ch.func, req_ch.queue_id, req_ch.data_in);
		if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
		    (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("[multi_queue_linked_pool] ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Receiver: switch between random stall patterns, and hold off for a long
	// stretch twice mid-run so the block backs up and stalls req.
	initial begin : receiver
		int unsigned pattern;
		int          pattern_left;
		int          seen;
		int          hold_left;
		bit          held_first;
		bit          held_second;
		pattern      = 0;
		pattern_left = 0;
		seen         = 0;
		hold_left    = 0;
		held_first   = 1'b0;
		held_second  = 1'b0;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
				seen++;
			if (!held_first && seen >= 200) begin
				held_first = 1'b1;
				hold_left  = HOLD_OFF_LEN;
			end
			if (!held_second && seen >= 650) begin
				held_second = 1'b1;
				hold_left   = HOLD_OFF_LEN;
			end
			if (pattern_left == 0) begin
				pattern      = $urandom_range(0, 3);
				pattern_left = $urandom_range(32, 128);
			end
			pattern_left--;
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				case (pattern)
					0: rsp_ch.ready <= 1'b1;
					1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
					2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
					default: rsp_ch.ready <= (pattern_left % 3 == 0);
				endcase
			end
		end
	end

	// Offer one request beat and hold it until the block takes it. Valid stays
	// high on return so back-to-back beats keep it asserted.
	task automatic send_request(input logic func, input logic [QUEUE_W-1:0] qid,
	                            input logic signed [DATA_WIDTH-1:0] data);
		req_ch.valid    <= 1'b1;
		req_ch.func     <= func;
		req_ch.queue_id <= qid;
		req_ch.data_in  <= data;
		do
			@(posedge clk);
		while (req_ch.ready !== 1'b1);
	endtask

	task automatic idle_gap(input int cycles);
		req_ch.valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Drop valid and wait until every owed response has come back.
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	initial begin : stimulus
		int                           sent;
		int                           phase;
		int                           phase_len;
		int unsigned                  enq_pct;
		int                           burst_left;
		int                           gap;
		logic                         func;
		logic [QUEUE_W-1:0]           qid;
		logic signed [DATA_WIDTH-1:0] data;

		arst_n          <= 1'b0;
		idle_cycles     <= 0;
		req_ch.valid    <= 1'b0;
		req_ch.func     <= FUNC_ENQ;
		req_ch.queue_id <= '0;
		req_ch.data_in  <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty dequeues on every queue number, including the one past
		// the last queue, and a dropped enqueue to that out-of-range number.
		send_request(FUNC_DEQ, 2'd0, 32'sd0);
		send_request(FUNC_DEQ, 2'd1, 32'sd0);
		send_request(FUNC_DEQ, 2'd2, 32'sd0);
		send_request(FUNC_DEQ, 2'd3, 32'sd0);
		send_request(FUNC_ENQ, 2'd3, 32'sh7fff_ffff);
		// Extreme values; dequeue until empty to hit the last-node case.
		send_request(FUNC_ENQ, 2'd0, 32'sh8000_0000);
		send_request(FUNC_ENQ, 2'd0, 32'sh7fff_ffff);
		send_request(FUNC_ENQ, 2'd1, 32'sd0);
		send_request(FUNC_ENQ, 2'd2, -32'sd1);
		send_request(FUNC_ENQ, 2'd1, -32'sd999);
		idle_gap(3);
		send_request(FUNC_DEQ, 2'd0, -32'sd1);
		send_request(FUNC_DEQ, 2'd0, 32'sd0);
		send_request(FUNC_DEQ, 2'd0, 32'sd0);
		send_request(FUNC_DEQ, 2'd1, 32'sd0);
		send_request(FUNC_DEQ, 2'd1, 32'sd0);
		send_request(FUNC_DEQ, 2'd2, 32'sd0);
		// Free list now holds nodes; reuse two of them from its top and dequeue them again.
		send_request(FUNC_ENQ, 2'd2, 32'sh5555_5555);
		send_request(FUNC_ENQ, 2'd2, 32'shaaaa_aaaa);
		send_request(FUNC_DEQ, 2'd2, 32'sd0);
		send_request(FUNC_DEQ, 2'd2, 32'sd0);
		wait_drained();

		// Random phases with a varying enqueue share. The first phase leans hard
		// on enqueue so the pool runs dry early; later ones drain and refill.
		sent       = 0;
		phase      = 0;
		burst_left = $urandom_range(1, 24);
		while (sent < RANDOM_BEATS) begin
			case (phase == 0 ? 0 : $urandom_range(0, 3))
				0: enq_pct = 90;
				1: enq_pct = 75;
				2: enq_pct = 50;
				default: enq_pct = 10;
			endcase
			phase_len = $urandom_range(50, 200);
			// Pause until fully drained after the first phase, then at random.
			if (phase == 1 || (phase > 1 && $urandom_range(0, 3) == 0))
				wait_drained();
			phase++;
			for (int i = 0; i < phase_len && sent < RANDOM_BEATS; i++) begin
				func = ($urandom_range(0, 99) < enq_pct) ? FUNC_ENQ : FUNC_DEQ;
				qid  = ($urandom_range(0, 15) == 0) ? QUEUE_W'(3)
				                                    : QUEUE_W'($urandom_range(0, NUM_QUEUES - 1));
				case ($urandom_range(0, 7))
					0: data = DATA_WIDTH'($urandom_range(0, 15));
					1: data = -DATA_WIDTH'($urandom_range(1, 16));
					default: data = $urandom;
				endcase
				send_request(func, qid, data);
				sent++;
				burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 24);
					gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					if (gap > 0)
						idle_gap(gap);
				end
			end
		end

		// Wait out the owed responses, then keep watching for stray responses.
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0) begin
			$display("[multi_queue_linked_pool] OK");
		end else begin
			$display("[multi_queue_linked_pool] ERROR");
		end
		$finish;
	end

endmodule
